// ----- rtl/core/rtp_reorder_pacing_buffer_defines.svh -----
// Assertion macros used by the checker file of the reorder and pacing buffer
`ifndef RTP_REORDER_PACING_BUFFER_DEFINES_SVH
`define RTP_REORDER_PACING_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define RPB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rpb_pkg.sv -----
// Shared types, codes and helpers of the reorder and pacing buffer
package rpb_pkg;

  localparam int SEQ_W   = 16;
  localparam int STAMP_W = 32;
  localparam int LAT_W   = 40;
  localparam int JIT_W   = 24;
  localparam int LEVEL_W = 6;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int GAP_W   = 41;
  localparam int TICKS_PER_STAMP = 300;

  localparam logic [LAT_W-1:0] LATENCY_RST = LAT_W'(5400000);
  localparam logic [JIT_W-1:0] JITTER_RST  = JIT_W'(27000);

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_NONE      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RELEASED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_QUEUED    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DROP_BAD  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DROP_FULL = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER  = 1'b1;

  // Item kind decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_ARRIVE,
    KIND_BAD
  } item_kind_e;

  // True when sequence a goes before sequence b, modulo 2^16
  function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] m;
    logic             r;
    m = a - b;
    if (m == '0) begin
      r = 1'b0;
    end else if (m == 16'h8000) begin
      r = (a > b);
    end else begin
      r = m[SEQ_W-1];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/rpb_front.sv -----
// Front end: accepts items, classifies them and holds them in a two-entry queue
module rpb_front #(
  parameter int TAG_BITS  = 10,
  parameter int TIME_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_op_i,
  input  logic [TIME_BITS-1:0]         in_now_i,
  input  logic [TAG_BITS-1:0]          in_tag_i,
  input  logic [rpb_pkg::SEQ_W-1:0]    in_seq_i,
  input  logic [rpb_pkg::STAMP_W-1:0]  in_stamp_i,
  input  logic                         in_hdr_ok_i,
  output logic                         q_valid_o,
  input  logic                         q_pop_i,
  output rpb_pkg::item_kind_e          q_kind_o,
  output logic [TIME_BITS-1:0]         q_now_o,
  output logic [TAG_BITS-1:0]          q_tag_o,
  output logic [rpb_pkg::SEQ_W-1:0]    q_seq_o,
  output logic [rpb_pkg::STAMP_W-1:0]  q_stamp_o
);
  import rpb_pkg::*;

  item_kind_e           kind_q  [2];
  logic [TIME_BITS-1:0] now_q   [2];
  logic [TAG_BITS-1:0]  tag_q   [2];
  logic [SEQ_W-1:0]     seq_q   [2];
  logic [STAMP_W-1:0]   stamp_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  item_kind_e           kind_in;
  logic                 push;

  // Classify the incoming item
  always_comb begin
    if (!in_op_i) begin
      kind_in = KIND_TICK;
    end else if (in_hdr_ok_i) begin
      kind_in = KIND_ARRIVE;
    end else begin
      kind_in = KIND_BAD;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item in the queue slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q]  <= kind_in;
      now_q[wr_ptr_q]   <= in_now_i;
      tag_q[wr_ptr_q]   <= in_tag_i;
      seq_q[wr_ptr_q]   <= in_seq_i;
      stamp_q[wr_ptr_q] <= in_stamp_i;
    end
  end

  assign q_kind_o  = kind_q[rd_ptr_q];
  assign q_now_o   = now_q[rd_ptr_q];
  assign q_tag_o   = tag_q[rd_ptr_q];
  assign q_seq_o   = seq_q[rd_ptr_q];
  assign q_stamp_o = stamp_q[rd_ptr_q];

endmodule

// ----- rtl/core/rpb_back.sv -----
// Back end: sorted cell row, release pacing and the result register
module rpb_back #(
  parameter int DEPTH     = 32,
  parameter int TAG_BITS  = 10,
  parameter int TIME_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rpb_pkg::LAT_W-1:0]      cfg_data_i,
  input  logic                           q_valid_i,
  output logic                           q_pop_o,
  input  rpb_pkg::item_kind_e            q_kind_i,
  input  logic [TIME_BITS-1:0]           q_now_i,
  input  logic [TAG_BITS-1:0]            q_tag_i,
  input  logic [rpb_pkg::SEQ_W-1:0]      q_seq_i,
  input  logic [rpb_pkg::STAMP_W-1:0]    q_stamp_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rpb_pkg::STAT_W-1:0]     out_status_o,
  output logic [TAG_BITS-1:0]            out_tag_o,
  output logic [rpb_pkg::SEQ_W-1:0]      out_seq_o,
  output logic                           out_missed_o,
  output logic                           out_capped_o,
  output logic [rpb_pkg::LEVEL_W-1:0]    out_level_o
);
  import rpb_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_PACE
  } state_e;

  // Cell row, oldest packet in cell 0
  logic [TAG_BITS-1:0] cell_tag_q   [DEPTH];
  logic [SEQ_W-1:0]    cell_seq_q   [DEPTH];
  logic [STAMP_W-1:0]  cell_stamp_q [DEPTH];

  state_e               state_q;
  logic [CNT_W-1:0]     count_q;
  logic [TIME_BITS-1:0] next_rel_q;
  logic                 armed_q;
  logic [LAT_W-1:0]     latency_q;
  logic [JIT_W-1:0]     jitter_q;
  logic [GAP_W-1:0]     gap_q;

  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [TAG_BITS-1:0]  out_tag_q;
  logic [SEQ_W-1:0]     out_seq_q;
  logic                 out_missed_q;
  logic                 out_capped_q;
  logic [LEVEL_W-1:0]   out_level_q;

  logic                 out_free;
  logic                 take;
  logic                 full;
  logic [TIME_BITS-1:0] late;
  logic                 due;
  logic                 do_insert;
  logic                 do_release;
  logic [DEPTH:0]       sfx;
  logic [STAMP_W-1:0]   stamp_diff;
  logic [GAP_W-1:0]     gap_d;
  logic                 gap_over;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = (state_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = take;
  assign full     = (count_q == CNT_W'(DEPTH));
  assign late     = q_now_i - next_rel_q;
  assign due      = !late[TIME_BITS-1];

  assign do_insert  = take && (q_kind_i == KIND_ARRIVE) && !full;
  assign do_release = take && (q_kind_i == KIND_TICK) && armed_q &&
                      (count_q != '0) && due;

  // Suffix of cells that the new packet goes before
  always_comb begin
    sfx[DEPTH] = 1'b1;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (CNT_W'(j) >= count_q) begin
        sfx[j] = 1'b1;
      end else begin
        sfx[j] = seq_before(q_seq_i, cell_seq_q[j]) && sfx[j+1];
      end
    end
  end

  // Pacing gap of the packet that follows the released one
  assign stamp_diff = cell_stamp_q[(DEPTH > 1) ? 1 : 0] - cell_stamp_q[0];
  assign gap_d      = GAP_W'(stamp_diff) * GAP_W'(TICKS_PER_STAMP);
  assign gap_over   = gap_q > GAP_W'(latency_q);

  // Shift or insert in the cell row
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_insert) begin
        if (i > 0 && sfx[(i > 0) ? i - 1 : 0]) begin
          cell_tag_q[i]   <= cell_tag_q[(i > 0) ? i - 1 : 0];
          cell_seq_q[i]   <= cell_seq_q[(i > 0) ? i - 1 : 0];
          cell_stamp_q[i] <= cell_stamp_q[(i > 0) ? i - 1 : 0];
        end else if (sfx[i]) begin
          cell_tag_q[i]   <= q_tag_i;
          cell_seq_q[i]   <= q_seq_i;
          cell_stamp_q[i] <= q_stamp_i;
        end
      end else if (do_release && i < DEPTH - 1) begin
        cell_tag_q[i]   <= cell_tag_q[(i < DEPTH - 1) ? i + 1 : i];
        cell_seq_q[i]   <= cell_seq_q[(i < DEPTH - 1) ? i + 1 : i];
        cell_stamp_q[i] <= cell_stamp_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latency_q <= LATENCY_RST;
      jitter_q  <= JITTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LATENCY: latency_q <= cfg_data_i;
        CFG_JITTER:  jitter_q  <= cfg_data_i[JIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, pacing state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      next_rel_q   <= '0;
      armed_q      <= 1'b0;
      gap_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_NONE;
      out_tag_q    <= '0;
      out_seq_q    <= '0;
      out_missed_q <= 1'b0;
      out_capped_q <= 1'b0;
      out_level_q  <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            out_tag_q    <= '0;
            out_seq_q    <= '0;
            out_missed_q <= 1'b0;
            out_capped_q <= 1'b0;
            out_level_q  <= LEVEL_W'(count_q);
            out_status_q <= STAT_NONE;
            out_valid_q  <= 1'b1;
            unique case (q_kind_i)
              KIND_BAD: begin
                out_status_q <= STAT_DROP_BAD;
              end
              KIND_ARRIVE: begin
                if (full) begin
                  out_status_q <= STAT_DROP_FULL;
                end else begin
                  count_q      <= count_q + 1'b1;
                  out_level_q  <= LEVEL_W'(count_q + 1'b1);
                  out_status_q <= STAT_QUEUED;
                  if (!armed_q) begin
                    next_rel_q <= q_now_i + TIME_BITS'(latency_q);
                    armed_q    <= 1'b1;
                  end
                end
              end
              KIND_TICK: begin
                if (armed_q && count_q == '0) begin
                  armed_q <= 1'b0;
                end else if (do_release) begin
                  count_q      <= count_q - 1'b1;
                  out_level_q  <= LEVEL_W'(count_q - 1'b1);
                  out_status_q <= STAT_RELEASED;
                  out_tag_q    <= cell_tag_q[0];
                  out_seq_q    <= cell_seq_q[0];
                  out_missed_q <= (late >= TIME_BITS'(jitter_q));
                  if (count_q == CNT_W'(1)) begin
                    armed_q <= 1'b0;
                  end else begin
                    // Hold the result until the next release time is settled
                    out_valid_q <= 1'b0;
                    gap_q       <= gap_d;
                    state_q     <= S_PACE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_PACE: begin
          if (gap_over) begin
            next_rel_q   <= next_rel_q + TIME_BITS'(latency_q);
            out_capped_q <= 1'b1;
          end else begin
            next_rel_q <= next_rel_q + TIME_BITS'(gap_q);
          end
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_tag_o    = out_tag_q;
  assign out_seq_o    = out_seq_q;
  assign out_missed_o = out_missed_q;
  assign out_capped_o = out_capped_q;
  assign out_level_o  = out_level_q;

endmodule

// ----- rtl/core/rtp_reorder_pacing_buffer.sv -----
// Top level of the RTP reorder and pacing buffer
// Packet descriptors enter on the slave stream and are kept sorted by RTP
// sequence number in a row of DEPTH cells; time ticks release the oldest
// packet once its release time is reached, and every item gives exactly one
// result on the master stream. Each item first lands in a two-entry queue
// and is then taken by the back end; a release that leaves packets behind
// also passes the pacing state: the timestamp gap times 300 is registered
// before it is compared with the latency and added to the release time.
// There is no clearing pass after reset; the block takes items from the
// first cycle.
module rtp_reorder_pacing_buffer #(
  parameter int DEPTH     = 32,
  parameter int TAG_BITS  = 10,
  parameter int TIME_BITS = 48,
  localparam int IN_W   = TIME_BITS + TAG_BITS + rpb_pkg::SEQ_W + rpb_pkg::STAMP_W + 1,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = TAG_BITS + rpb_pkg::SEQ_W + 2 + rpb_pkg::LEVEL_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rpb_pkg::LAT_W-1:0]     cfg_data_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // now, packet_tag, seq_number, rtp_stamp, header_ok, zero fill
  input  logic [IN_TW-1:0]              s_tdata_i,
  // op
  input  logic                          s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // sent_tag, sent_seq, deadline_missed, delay_capped, queue_level, zero fill
  output logic [OUT_TW-1:0]             m_tdata_o,
  // status
  output logic [rpb_pkg::STAT_W-1:0]    m_tuser_o
);
  import rpb_pkg::*;

  localparam int TAG_LO   = TIME_BITS;
  localparam int SEQ_LO   = TAG_LO + TAG_BITS;
  localparam int STAMP_LO = SEQ_LO + SEQ_W;
  localparam int HDR_LO   = STAMP_LO + STAMP_W;

  logic                 q_valid;
  logic                 q_pop;
  item_kind_e           q_kind;
  logic [TIME_BITS-1:0] q_now;
  logic [TAG_BITS-1:0]  q_tag;
  logic [SEQ_W-1:0]     q_seq;
  logic [STAMP_W-1:0]   q_stamp;
  logic [TAG_BITS-1:0]  out_tag;
  logic [SEQ_W-1:0]     out_seq;
  logic                 out_missed;
  logic                 out_capped;
  logic [LEVEL_W-1:0]   out_level;

  rpb_front #(
    .TAG_BITS  (TAG_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_op_i     (s_tuser_i),
    .in_now_i    (s_tdata_i[TIME_BITS-1:0]),
    .in_tag_i    (s_tdata_i[SEQ_LO-1:TAG_LO]),
    .in_seq_i    (s_tdata_i[STAMP_LO-1:SEQ_LO]),
    .in_stamp_i  (s_tdata_i[HDR_LO-1:STAMP_LO]),
    .in_hdr_ok_i (s_tdata_i[HDR_LO]),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_kind_o    (q_kind),
    .q_now_o     (q_now),
    .q_tag_o     (q_tag),
    .q_seq_o     (q_seq),
    .q_stamp_o   (q_stamp)
  );

  rpb_back #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_kind_i     (q_kind),
    .q_now_i      (q_now),
    .q_tag_i      (q_tag),
    .q_seq_i      (q_seq),
    .q_stamp_i    (q_stamp),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_status_o (m_tuser_o),
    .out_tag_o    (out_tag),
    .out_seq_o    (out_seq),
    .out_missed_o (out_missed),
    .out_capped_o (out_capped),
    .out_level_o  (out_level)
  );

  // Pack the result fields, lowest field first
  assign m_tdata_o = OUT_TW'({out_level, out_capped, out_missed, out_seq, out_tag});

endmodule

// ----- rtl/core/rpb_checker.sv -----
// Port-level checks of the reorder and pacing buffer, bound to the top level
`include "rtp_reorder_pacing_buffer_defines.svh"

module rpb_checker #(
  parameter int DEPTH    = 32,
  parameter int TAG_BITS = 10,
  parameter int OUT_TW   = 40
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_tvalid_i,
  input logic                       m_tready_i,
  input logic [OUT_TW-1:0]          m_tdata_i,
  input logic [rpb_pkg::STAT_W-1:0] m_tuser_i
);
  import rpb_pkg::*;

  localparam int REL_W    = TAG_BITS + SEQ_W + 2;
  localparam int LEVEL_LO = REL_W;
  localparam bit LEVEL_WRAPS = (DEPTH >= (1 << LEVEL_W));

  // A stalled result holds
  `RPB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i), "stalled result changed")

  // Release fields stay zero unless a packet is released
  `RPB_ASSERT_IMPLIES(a_rel_fields, clk_i, rst_ni, m_tvalid_i && (m_tuser_i != STAT_RELEASED), m_tdata_i[REL_W-1:0] == '0, "release fields set without a release")

  // The level never exceeds the store depth
  `RPB_ASSERT_IMPLIES(a_level, clk_i, rst_ni, m_tvalid_i, LEVEL_WRAPS || (m_tdata_i[LEVEL_LO+LEVEL_W-1:LEVEL_LO] <= LEVEL_W'(DEPTH)), "queue level above depth")

  // Only defined status codes appear
  `RPB_ASSERT_IMPLIES(a_status, clk_i, rst_ni, m_tvalid_i, m_tuser_i <= STAT_DROP_FULL, "undefined status code")

endmodule

bind rtp_reorder_pacing_buffer rpb_checker #(
  .DEPTH    (DEPTH),
  .TAG_BITS (TAG_BITS),
  .OUT_TW   (OUT_TW)
) u_rpb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tuser_i  (m_tuser_o)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the RTP reorder and pacing buffer
`timescale 1ns / 100ps

module tb;
  import rpb_pkg::*;

  localparam int DEPTH     = 32;
  localparam int TAG_BITS  = 10;
  localparam int TIME_BITS = 48;
  localparam int IN_TW     = 112;
  localparam int OUT_TW    = 40;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  // Release predictor: sorted packet store, pacing state and expected results
  class pacing_predictor;
    typedef struct {
      logic [STAT_W-1:0]   status;
      logic [TAG_BITS-1:0] tag;
      logic [SEQ_W-1:0]    seq;
      logic                missed;
      logic                capped;
      logic [LEVEL_W-1:0]  level;
    } result_t;

    logic [TAG_BITS-1:0]  tags [DEPTH];
    logic [SEQ_W-1:0]     seqs [DEPTH];
    logic [STAMP_W-1:0]   stamps [DEPTH];
    int                   count;
    logic [TIME_BITS-1:0] due;
    logic                 armed;
    logic [LAT_W-1:0]     latency;
    logic [JIT_W-1:0]     jitter;
    result_t              pending_results[$];
    int                   errors;
    int                   released, queued, dropped_bad, dropped_full, capped_cnt, missed_cnt;

    function new();
      count = 0; due = '0; armed = 1'b0;
      latency = LATENCY_RST; jitter = JITTER_RST;
      errors = 0; released = 0; queued = 0; dropped_bad = 0; dropped_full = 0;
      capped_cnt = 0; missed_cnt = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] val);
      if (idx == CFG_LATENCY) latency = val;
      else jitter = val[JIT_W-1:0];
    endfunction

    // Wrap-aware order: true when a goes before b
    function bit goes_first(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      if (d == '0) return 0;
      if (d == 16'h8000) return a > b;
      return d[SEQ_W-1];
    endfunction

    // Note an accepted item and queue its expected result
    function void note_item(bit is_arrival, logic [TIME_BITS-1:0] now,
                            logic [TAG_BITS-1:0] tag, logic [SEQ_W-1:0] seq,
                            logic [STAMP_W-1:0] stamp, bit hdr_ok);
      result_t r;
      int i;
      logic [TIME_BITS-1:0] late;
      logic [STAMP_W-1:0] head_stamp, sdiff;
      logic [63:0] gap;
      r = '{default: '0};
      if (is_arrival) begin
        if (!hdr_ok) begin
          r.status = STAT_DROP_BAD; dropped_bad++;
        end else if (count >= DEPTH) begin
          r.status = STAT_DROP_FULL; dropped_full++;
        end else begin
          i = count;
          while (i > 0 && goes_first(seq, seqs[i-1])) begin
            tags[i] = tags[i-1]; seqs[i] = seqs[i-1]; stamps[i] = stamps[i-1];
            i--;
          end
          tags[i] = tag; seqs[i] = seq; stamps[i] = stamp;
          count++;
          if (!armed) begin
            due = now + TIME_BITS'(latency);
            armed = 1'b1;
          end
          r.status = STAT_QUEUED; queued++;
        end
      end else if (armed) begin
        late = now - due;
        if (count == 0) begin
          armed = 1'b0;
        end else if (!late[TIME_BITS-1]) begin
          head_stamp = stamps[0];
          r.status = STAT_RELEASED; released++;
          r.tag = tags[0];
          r.seq = seqs[0];
          r.missed = (late >= TIME_BITS'(jitter));
          if (r.missed) missed_cnt++;
          for (i = 1; i < count; i++) begin
            tags[i-1] = tags[i]; seqs[i-1] = seqs[i]; stamps[i-1] = stamps[i];
          end
          count--;
          if (count == 0) begin
            armed = 1'b0;
          end else begin
            sdiff = stamps[0] - head_stamp;
            gap = 64'(sdiff) * TICKS_PER_STAMP;
            if (gap > 64'(latency)) begin
              due = due + TIME_BITS'(latency);
              r.capped = 1'b1; capped_cnt++;
            end else begin
              due = due + TIME_BITS'(gap);
            end
          end
        end
      end
      r.level = LEVEL_W'(count);
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(logic [STAT_W-1:0] status, logic [OUT_TW-1:0] data);
      result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0h data %0h", $time, status, data);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      cmp("status", r.status, status);
      cmp("sent_tag", r.tag, data[9:0]);
      cmp("sent_seq", r.seq, data[25:10]);
      cmp("deadline_missed", r.missed, data[26]);
      cmp("delay_capped", r.capped, data[27]);
      cmp("queue_level", r.level, data[33:28]);
      cmp("zero fill", '0, data[OUT_TW-1:34]);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [LAT_W-1:0]       cfg_data_i;
  logic                   s_tvalid_i;
  logic                   s_tready_o;
  logic [IN_TW-1:0]       s_tdata_i;
  logic                   s_tuser_i;
  logic                   m_tvalid_o;
  logic                   m_tready_i;
  logic [OUT_TW-1:0]      m_tdata_o;
  logic [STAT_W-1:0]      m_tuser_o;

  pacing_predictor pred = new();
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_off = 0;
  longint unsigned cycles = 0;
  logic [TIME_BITS-1:0] cur_now = '0;
  logic [SEQ_W-1:0]     seq_ctr;
  logic [STAMP_W-1:0]   stamp_ctr;
  int              items_sent = 0;

  rtp_reorder_pacing_buffer uut (.*);

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[rtp_reorder_pacing_buffer] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, long hold-off on request, check each result
  always @(posedge clk_i) begin
    if (m_tvalid_o && m_tready_i) pred.check_result(m_tuser_o, m_tdata_o);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one item, hold it until accepted, then maybe idle
  task automatic send_item(bit op, logic [TIME_BITS-1:0] now, logic [TAG_BITS-1:0] tag,
                           logic [SEQ_W-1:0] seq, logic [STAMP_W-1:0] stamp, bit ok);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {5'd0, ok, stamp, seq, tag, now};
    do @(posedge clk_i); while (!s_tready_o);
    pred.note_item(op, now, tag, seq, stamp, ok);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  // Withdraw the last item at once, then wait for all results
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (pred.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // One random item: mostly paced streams, some noise
  task automatic random_item(int step_max);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_item($urandom_range(0, 1), rand_time(), $urandom, $urandom, $urandom,
                $urandom_range(0, 1));
    end else if (pick < 55) begin
      send_item(1'b1, cur_now + $urandom_range(0, 50), $urandom,
                seq_ctr + $urandom_range(0, 4), stamp_ctr + $urandom_range(0, 30),
                $urandom_range(0, 19) != 0);
      if ($urandom_range(0, 1)) begin
        seq_ctr++;
        stamp_ctr += $urandom_range(0, 12);
      end
    end else begin
      cur_now += $urandom_range(0, step_max);
      send_item(1'b0, cur_now, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int lat_tab [5] = '{1000, 3000, 0, -1, 2000};
    int step_tab[5] = '{1500, 4500, 600, 4000, 3000};
    logic [JIT_W-1:0] jit_tab [5] = '{0, 24'hFFFFFF, 50, 500, 300};
    int send_tab[5] = '{0, 80, 0, 21, 0};
    int recv_tab[5] = '{0, 0, 80, 21, 0};
    logic [LAT_W-1:0] lat;
    logic [TIME_BITS-1:0] t0;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0; cfg_idx_i <= CFG_LATENCY; cfg_data_i <= '0;
    s_tvalid_i <= 1'b0; s_tuser_i <= 1'b0; s_tdata_i <= '0;
    m_tready_i <= 1'b0;
    seq_ctr = $urandom; stamp_ctr = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings
    t0 = 48'hFFFF_FFF0_0000;
    send_item(1'b0, t0, 0, 0, 0, 1);                         // tick with nothing armed
    send_item(1'b1, t0, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 0); // bad header
    send_item(1'b1, t0, 10'h000, 16'h0000, 32'h0000_0000, 1); // arms, now+latency wraps
    send_item(1'b1, t0, 10'h3FF, 16'h8000, 32'hFFFF_FFFF, 1); // half-range apart
    send_item(1'b1, t0, 10'h155, 16'h0000, 32'h0000_0010, 1); // equal sequence
    send_item(1'b1, t0, 10'h2AA, 16'hFFFF, 32'h0000_0005, 1); // wraps before zero
    send_item(1'b0, t0 + 48'd5399999, 0, 0, 0, 1);           // one tick short of due
    send_item(1'b0, t0 + 48'd5400000, 0, 0, 0, 1);           // exactly due
    send_item(1'b0, t0 + 48'd5400000 + 48'd27000 + 48'd4000, 0, 0, 0, 1);
    send_item(1'b0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 1);         // far early: no release
    send_item(1'b0, t0 + 48'd90000000, 0, 0, 0, 1);
    send_item(1'b0, t0 + 48'd190000000, 0, 0, 0, 1);         // empties, disarms
    send_item(1'b0, t0 + 48'd290000000, 0, 0, 0, 1);         // nothing left
    drain();

    for (int p = 0; p < 5; p++) begin
      lat = (lat_tab[p] < 0) ? {LAT_W{1'b1}} : LAT_W'(lat_tab[p]);
      write_reg(CFG_LATENCY, lat);
      write_reg(CFG_JITTER, LAT_W'(jit_tab[p]));
      send_idle_pct  = send_tab[p];
      recv_stall_pct = recv_tab[p];
      if (p == 4) begin
        // Long receiver hold-off while arrivals pile up past the store depth
        hold_off = 400;
        for (int k = 0; k < 50; k++)
          send_item(1'b1, cur_now, $urandom, seq_ctr + k, stamp_ctr + k, 1);
        seq_ctr += 50;
        stamp_ctr += 50;
      end
      for (int k = 0; k < 200; k++) random_item(step_tab[p]);
      // Phase with no idling at all in between
      send_idle_pct = 0; recv_stall_pct = 0;
      for (int k = 0; k < 20; k++) random_item(step_tab[p]);
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("%0d items: %0d queued, %0d released (%0d late, %0d capped), %0d bad, %0d full",
             items_sent, pred.queued, pred.released, pred.missed_cnt, pred.capped_cnt,
             pred.dropped_bad, pred.dropped_full);
    $display("five register settings incl. zero and full-scale latency, stalls on both sides");
    if (pred.errors == 0 && pred.pending_results.size() == 0) begin
      $display("[rtp_reorder_pacing_buffer] OK");
    end else begin
      $display("[rtp_reorder_pacing_buffer] ERROR");
    end
    $finish;
  end

endmodule

// ----- rtp_reorder_pacing_buffer.f -----
+incdir+rtl/core
rtl/core/rpb_pkg.sv
rtl/core/rpb_front.sv
rtl/core/rpb_back.sv
rtl/core/rtp_reorder_pacing_buffer.sv
rtl/core/rpb_checker.sv
dv/tb.sv
